FILE: src/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants of the physical frame allocator: command and
// result words, action and status codes, free list control and status.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int MAX_FRAMES = 256;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int COUNT_W    = FRAME_W + 1;
  localparam int OWNER_W    = 8;

  typedef enum logic [2:0] {
    ACT_TAKE    = 3'd0,
    ACT_RETURN  = 3'd1,
    ACT_ALLOC   = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_QUERY   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_REFUSED  = 2'd3
  } status_t;

  // command word
  typedef struct packed {
    logic [2:0]         action;
    logic [FRAME_W-1:0] frame;
    logic [OWNER_W-1:0] owner_in;
  } cmd_t;

  // result word
  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] frame_out;
    logic [OWNER_W-1:0] owner_out;
    logic               is_free;
    logic [COUNT_W-1:0] free_total;
    logic [COUNT_W-1:0] used_total;
  } result_t;

  // free list requests from the action decode
  typedef struct packed {
    logic               pop;
    logic               push;
    logic [FRAME_W-1:0] push_frame;
  } fl_ctl_t;

  // free list state seen by the action decode
  typedef struct packed {
    logic               avail;
    logic               can_push;
    logic [FRAME_W-1:0] pop_frame;
  } fl_stat_t;

endpackage

FILE: src/pfa_owner_store.sv
// ----------------------------------------------------------------------------
// pfa_owner_store
// Owner id memory, one entry per frame, registered read with write bypass.
// ----------------------------------------------------------------------------
module pfa_owner_store
  import pfa_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [FRAME_W-1:0] wr_addr,
  input  logic [OWNER_W-1:0] wr_data,
  input  logic [FRAME_W-1:0] rd_addr,
  output logic [OWNER_W-1:0] rd_data
);

  logic [OWNER_W-1:0] mem [MAX_FRAMES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, a same-edge write to the read address wins
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/pfa_free_list.sv
// ----------------------------------------------------------------------------
// pfa_free_list
// LIFO free list: a stack of returned frames in memory served first, then
// fresh frames issued in ascending order below the configured count.
// ----------------------------------------------------------------------------
module pfa_free_list
  import pfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] frame_count,
  input  fl_ctl_t            ctl,
  output fl_stat_t           stat,
  output logic [COUNT_W-1:0] free_total
);

  logic [FRAME_W-1:0] stack_mem [MAX_FRAMES];
  logic [COUNT_W-1:0] depth;
  logic [COUNT_W-1:0] depth_next;
  logic [COUNT_W-1:0] fresh_next;
  logic [COUNT_W-1:0] fresh_next_next;
  logic [FRAME_W-1:0] top_word;
  logic [COUNT_W-1:0] depth_m1;
  logic [COUNT_W-1:0] fresh_left;
  logic [COUNT_W:0]   total_sum;
  logic               stack_we;
  logic [FRAME_W-1:0] stack_waddr;
  logic [FRAME_W-1:0] stack_raddr;

  // top of list as seen by the current word
  assign stat.avail     = (depth != '0) || (fresh_next < frame_count);
  assign stat.can_push  = depth < COUNT_W'(MAX_FRAMES);
  assign stat.pop_frame = (depth != '0) ? top_word : fresh_next[FRAME_W-1:0];

  // pointer updates
  always_comb begin
    depth_next      = depth;
    fresh_next_next = fresh_next;
    stack_we        = 1'b0;
    stack_waddr     = depth[FRAME_W-1:0];
    if (ctl.pop) begin
      if (depth != '0) begin
        depth_next = depth - 1'b1;
      end else begin
        fresh_next_next = fresh_next + 1'b1;
      end
    end else if (ctl.push && stat.can_push) begin
      stack_we   = 1'b1;
      depth_next = depth + 1'b1;
    end
  end

  // prefetch the entry that will be on top after this word
  assign depth_m1    = depth_next - 1'b1;
  assign stack_raddr = depth_m1[FRAME_W-1:0];

  // free count after this word
  assign fresh_left = (frame_count > fresh_next_next) ? (frame_count - fresh_next_next) : '0;
  assign total_sum  = {1'b0, depth_next} + {1'b0, fresh_left};
  assign free_total = total_sum[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= '0;
      fresh_next <= '0;
    end else begin
      depth      <= depth_next;
      fresh_next <= fresh_next_next;
    end
  end

  // stack memory write
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= ctl.push_frame;
    end
  end

  // stack memory read with bypass of a push to the same entry
  always_ff @(posedge clk) begin
    if (stack_we && (stack_waddr == stack_raddr)) begin
      top_word <= ctl.push_frame;
    end else begin
      top_word <= stack_mem[stack_raddr];
    end
  end

endmodule

FILE: src/physical_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// physical_frame_allocator_core
// Frame allocator for a paged memory: take, return, allocate, release, query.
// ----------------------------------------------------------------------------
// A command word is taken at any edge with start high and busy low; busy is
// high only during reset. One command is taken every cycle. Its result word
// is on result with done high for exactly one cycle, once the command has
// passed the input register and then the result register. Results come in
// command order and cannot be held off. The rate rests on the update of the
// free list pointer and the frame marks from the registered command, with the
// stack top and owner id prefetched from their memories into registers. Reset
// sets every free mark and clears every used mark at once; no clearing pass.
// frame_count may be written on the cfg channel only while no command is in
// flight; values above the frame capacity saturate.
module physical_frame_allocator_core
  import pfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cmd_t               cmd,
  output logic               done,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  logic               in_valid;
  cmd_t               in_word;
  logic [COUNT_W-1:0] frame_count;
  logic [MAX_FRAMES-1:0] free_mark;
  logic [MAX_FRAMES-1:0] used_mark;
  logic [COUNT_W-1:0] used_frames;
  logic [COUNT_W-1:0] used_frames_next;
  fl_ctl_t            fl_ctl;
  fl_stat_t           fl_stat;
  logic [COUNT_W-1:0] free_total;
  logic [OWNER_W-1:0] owner_rd;
  logic               owner_we;
  logic               free_clr;
  logic               free_set;
  logic               used_set;
  logic               used_clr;
  logic               in_range;
  logic               cur_free;
  logic               cur_used;
  result_t            result_next;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= COUNT_W'(MAX_FRAMES);
    end else if (cfg_valid && cfg_ready) begin
      frame_count <= (cfg_data > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES) : cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_word <= cmd;
  end

  pfa_free_list u_free_list (
    .clk         (clk),
    .rst         (rst),
    .frame_count (frame_count),
    .ctl         (fl_ctl),
    .stat        (fl_stat),
    .free_total  (free_total)
  );

  pfa_owner_store u_owner_store (
    .clk     (clk),
    .wr_en   (owner_we),
    .wr_addr (fl_stat.pop_frame),
    .wr_data (in_word.owner_in),
    .rd_addr (cmd.frame),
    .rd_data (owner_rd)
  );

  assign in_range = {1'b0, in_word.frame} < frame_count;
  assign cur_free = free_mark[in_word.frame];
  assign cur_used = used_mark[in_word.frame];

  // action decode
  always_comb begin
    fl_ctl.pop        = 1'b0;
    fl_ctl.push       = 1'b0;
    fl_ctl.push_frame = in_word.frame;
    owner_we          = 1'b0;
    free_clr          = 1'b0;
    free_set          = 1'b0;
    used_set          = 1'b0;
    used_clr          = 1'b0;
    used_frames_next  = used_frames;
    result_next.status    = ST_OK;
    result_next.frame_out = in_word.frame;
    result_next.owner_out = '0;
    result_next.is_free   = 1'b0;
    if (in_valid) begin
      case (in_word.action)
        ACT_TAKE: begin
          if (fl_stat.avail) begin
            fl_ctl.pop            = 1'b1;
            free_clr              = 1'b1;
            result_next.frame_out = fl_stat.pop_frame;
          end else begin
            result_next.status    = ST_NO_FREE;
            result_next.frame_out = '0;
          end
        end
        ACT_RETURN: begin
          if (!in_range || cur_free || cur_used) begin
            result_next.status = ST_REFUSED;
          end else begin
            fl_ctl.push = 1'b1;
            free_set    = fl_stat.can_push;
          end
        end
        ACT_ALLOC: begin
          if (fl_stat.avail) begin
            fl_ctl.pop            = 1'b1;
            free_clr              = 1'b1;
            used_set              = 1'b1;
            owner_we              = 1'b1;
            used_frames_next      = used_frames + 1'b1;
            result_next.frame_out = fl_stat.pop_frame;
          end else begin
            result_next.status    = ST_NO_FREE;
            result_next.frame_out = '0;
          end
        end
        ACT_RELEASE: begin
          if (!in_range) begin
            result_next.status = ST_REFUSED;
          end else if (!cur_used) begin
            result_next.status = cur_free ? ST_REFUSED : ST_NOT_FOUND;
          end else begin
            used_clr    = 1'b1;
            fl_ctl.push = 1'b1;
            free_set    = fl_stat.can_push;
            if (used_frames != '0) begin
              used_frames_next = used_frames - 1'b1;
            end
          end
        end
        ACT_QUERY: begin
          if (!in_range) begin
            result_next.status = ST_REFUSED;
          end else begin
            result_next.is_free = cur_free;
            if (cur_used) begin
              result_next.owner_out = owner_rd;
            end else begin
              result_next.status = ST_NOT_FOUND;
            end
          end
        end
        default: begin
          result_next.status = ST_REFUSED;
        end
      endcase
    end
    result_next.free_total = free_total;
    result_next.used_total = used_frames_next;
  end

  // frame marks and used count
  always_ff @(posedge clk) begin
    if (rst) begin
      free_mark   <= '1;
      used_mark   <= '0;
      used_frames <= '0;
    end else begin
      used_frames <= used_frames_next;
      if (free_clr) begin
        free_mark[fl_stat.pop_frame] <= 1'b0;
      end
      if (free_set) begin
        free_mark[in_word.frame] <= 1'b1;
      end
      if (used_set) begin
        used_mark[fl_stat.pop_frame] <= 1'b1;
      end
      if (used_clr) begin
        used_mark[in_word.frame] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    result <= result_next;
  end

endmodule
